// ===== hw/rtl/abs_second_derivative_histogram_defines.svh =====
// Assertion macros for the second derivative histogram block.
`ifndef ABS_SECOND_DERIVATIVE_HISTOGRAM_DEFINES_SVH
`define ABS_SECOND_DERIVATIVE_HISTOGRAM_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ASDH_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle check");

// Check that a condition implies another in the next cycle.
`define ASDH_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== hw/rtl/asdh_pkg.sv =====
// Shared constants and types of the second derivative histogram block.
`default_nettype none
package asdh_pkg;
    localparam int BIN_COUNT      = 256;
    localparam int BIN_W          = 8;
    localparam int COUNT_W        = 23;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam int PIX_W          = 8;
    localparam int DIM_W          = 12;
    localparam int STEP_W         = 5;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_STEP   = 16;
    localparam logic [DIM_W-1:0]  RST_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 12'd480;
    localparam logic [STEP_W-1:0] RST_STEP   = 5'd1;
    localparam logic [STEP_W-1:0] RST_INDENT = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STEP   = 2'd2,
        REG_INDENT = 2'd3
    } cfg_reg_t;
endpackage
`default_nettype wire

// ===== hw/rtl/asdh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module asdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/abs_second_derivative_histogram.sv =====
// Top level of the absolute second derivative histogram block.
// A pixel item (mode 0) whose arrival completes an interior center passes
// acceptance, the raster position update, four reads of the single read port
// of the line store, one histogram read and one histogram write; any other
// pixel goes from the position update to the line store write. A read item
// (mode 1) reads its bin, whose count then waits in the output register until
// taken; a further read item is held off until then. The histogram is cleared
// at once at the first pixel of a frame through per-bin valid bits, so there
// is no clearing pass. The line store holds 2*MAX_STEP*MAX_WIDTH pixels.
`default_nettype none
module abs_second_derivative_histogram #(
    parameter int MAX_WIDTH  = asdh_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = asdh_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_STEP   = asdh_pkg::DEF_MAX_STEP
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [asdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [asdh_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_mode,
    input  wire logic [asdh_pkg::PIX_W-1:0]     s_pixel,
    input  wire logic [asdh_pkg::BIN_W-1:0]     s_bin_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [asdh_pkg::COUNT_W-1:0]   m_bin_count
);
    import asdh_pkg::*;
    `include "abs_second_derivative_histogram_defines.svh"

    localparam int DEPTH = 2 * MAX_STEP * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int OW    = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CALC = 9'b000000010,
        S_RC   = 9'b000000100,
        S_RL   = 9'b000001000,
        S_RR   = 9'b000010000,
        S_RU   = 9'b000100000,
        S_WU   = 9'b001000000,
        S_HWR  = 9'b010000000,
        S_BOUT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [STEP_W-1:0] step_reg, indent_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     wr_ptr_reg;
    logic [PIX_W-1:0]  pix_reg, ctr_reg, lft_reg, rgt_reg;
    logic [BIN_W-1:0]  bin_reg, d_reg, d_next;
    logic              eval_reg, eval_next, frame_start;
    logic [OW-1:0]     sw_reg, sw_next;
    logic [BIN_COUNT-1:0] hvalid_reg;
    logic              m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic              accept;
    logic [OW-1:0]     off;
    logic [AW-1:0]     ls_raddr;
    logic [PIX_W-1:0]  ls_rdata;
    logic              ls_we;
    logic [BIN_W-1:0]  h_raddr;
    logic [COUNT_W-1:0] h_rdata, h_old, h_wdata;
    logic              h_we;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || !s_mode);
    assign m_valid = m_valid_reg;
    assign m_bin_count = m_count_reg;

    // position update, interior test and row offset
    always_comb begin
        logic [31:0] w, h, s, ind, c0, r0, c1, r1, y;
        logic        ok;
        w   = (width_reg == '0) ? 32'd1 :
              ((32'(width_reg) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(width_reg));
        h   = (height_reg == '0) ? 32'd1 :
              ((32'(height_reg) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(height_reg));
        s   = 32'(step_reg);
        ind = 32'(indent_reg);
        c0  = 32'(col_reg);
        r0  = 32'(row_reg);
        if (c0 >= w) begin
            c0 = 32'd0;
            r0 = r0 + 32'd1;
        end
        if (r0 >= h) begin
            r0 = 32'd0;
        end
        frame_start = (r0 == 32'd0) && (c0 == 32'd0);
        ok = (s >= 32'd1) && (s <= MAX_STEP) && (ind >= s) &&
             (w > 2 * ind) && (h > 2 * ind);
        y  = r0 - s;
        eval_next = ok && (r0 >= s) && (y >= ind) && (y < h - ind) &&
                    (c0 >= ind) && (c0 < w - ind);
        c1 = c0 + 32'd1;
        r1 = r0;
        if (c1 >= w) begin
            c1 = 32'd0;
            r1 = r1 + 32'd1;
            if (r1 >= h) begin
                r1 = 32'd0;
            end
        end
        col_next = c1[CW-1:0];
        row_next = r1[RW-1:0];
        sw_next  = OW'(s * w);
    end

    // neighbor address relative to the write pointer
    always_comb begin
        logic [31:0] a;
        unique case (state_reg)
            S_RL:    off = sw_reg + OW'(step_reg);
            S_RR:    off = sw_reg - OW'(step_reg);
            S_RU:    off = OW'({sw_reg, 1'b0});
            default: off = sw_reg;
        endcase
        a = 32'(wr_ptr_reg) + ((32'(wr_ptr_reg) < 32'(off)) ? 32'(DEPTH) : 32'd0)
            - 32'(off);
        ls_raddr = a[AW-1:0];
    end

    // second derivatives from the gathered neighbors
    always_comb begin
        logic [PIX_W:0]   sx, sy;
        logic [PIX_W-1:0] ax, ay, dx, dy;
        sx = ({1'b0, lft_reg} + {1'b0, rgt_reg} + 9'd1) >> 1;
        sy = ({1'b0, ls_rdata} + {1'b0, pix_reg} + 9'd1) >> 1;
        ax = sx[PIX_W-1:0];
        ay = sy[PIX_W-1:0];
        dx = (ax > ctr_reg) ? ax - ctr_reg : ctr_reg - ax;
        dy = (ay > ctr_reg) ? ay - ctr_reg : ctr_reg - ay;
        d_next = (dx > dy) ? dx : dy;
    end

    assign h_raddr = (state_reg == S_IDLE) ? s_bin_index : d_next;
    assign h_old   = hvalid_reg[d_reg] ? h_rdata : '0;
    assign h_wdata = h_old + COUNT_W'(1);
    assign h_we    = (state_reg == S_HWR) && eval_reg && (h_old != COUNT_MAX);
    assign ls_we   = (state_reg == S_HWR);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = s_mode ? S_BOUT : S_CALC;
            S_CALC: state_next = eval_next ? S_RC : S_HWR;
            S_RC:   state_next = S_RL;
            S_RL:   state_next = S_RR;
            S_RR:   state_next = S_RU;
            S_RU:   state_next = S_WU;
            S_WU:   state_next = S_HWR;
            S_HWR:  state_next = S_IDLE;
            S_BOUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            step_reg    <= RST_STEP;
            indent_reg  <= RST_INDENT;
            col_reg     <= '0;
            row_reg     <= '0;
            wr_ptr_reg  <= '0;
            hvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
            eval_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                    REG_INDENT: indent_reg <= cfg_data[STEP_W-1:0];
                endcase
            end
            if (state_reg == S_CALC) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                eval_reg <= eval_next;
                if (frame_start) begin
                    hvalid_reg <= '0;
                end
            end
            if (h_we) begin
                hvalid_reg[d_reg] <= 1'b1;
            end
            if (ls_we) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (state_reg == S_BOUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_pixel;
            bin_reg <= s_bin_index;
        end
        if (state_reg == S_CALC) sw_reg  <= sw_next;
        if (state_reg == S_RL)   ctr_reg <= ls_rdata;
        if (state_reg == S_RR)   lft_reg <= ls_rdata;
        if (state_reg == S_RU)   rgt_reg <= ls_rdata;
        if (state_reg == S_WU)   d_reg   <= d_next;
        if (state_reg == S_BOUT) begin
            m_count_reg <= hvalid_reg[bin_reg] ? h_rdata : '0;
        end
    end

    asdh_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
        .clk   (aclk),
        .we    (ls_we),
        .waddr (wr_ptr_reg),
        .wdata (pix_reg),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    asdh_ram #(.WIDTH(COUNT_W), .DEPTH(BIN_COUNT)) u_hist (
        .clk   (aclk),
        .we    (h_we),
        .waddr (d_reg),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    `ASDH_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != S_IDLE)
    `ASDH_ASSERT_NEXT(a_store_write_ends_item, state_reg == S_HWR, state_reg == S_IDLE)
    `ASDH_ASSERT_NOW(a_result_from_read, $rose(m_valid_reg), $past(state_reg) == S_BOUT)
    `ASDH_ASSERT_NOW(a_count_only_eval, h_we, eval_reg && (state_reg == S_HWR))
endmodule
`default_nettype wire

// ===== tb/sv/tb_abs_second_derivative_histogram.sv =====
// Testbench of the absolute second derivative histogram block: directed table, random frames.
`default_nettype none
module tb_abs_second_derivative_histogram;
    import asdh_pkg::*;

    localparam int STORE_DEPTH = 2 * DEF_MAX_STEP * DEF_MAX_WIDTH;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic mode;
        logic [PIX_W-1:0] pixel;
        logic [BIN_W-1:0] bin_index;
        logic check_fixed;
        logic [COUNT_W-1:0] fixed_count;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [PIX_W-1:0] s_pixel = '0;
    logic [BIN_W-1:0] s_bin_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [COUNT_W-1:0] m_bin_count;

    abs_second_derivative_histogram u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pixel(s_pixel), .s_bin_index(s_bin_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_bin_count(m_bin_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    int unsigned cfg_width = RST_WIDTH;
    int unsigned cfg_height = RST_HEIGHT;
    int unsigned cfg_step = RST_STEP;
    int unsigned cfg_indent = RST_INDENT;
    int unsigned hist_count [BIN_COUNT];
    logic [PIX_W-1:0] pixel_store [STORE_DEPTH];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned store_ptr = 0;

    logic [COUNT_W-1:0] expected_counts [$];
    logic [COUNT_W-1:0] fixed_counts [$];
    logic fixed_valid [$];
    int error_count = 0;
    int result_count = 0;
    int pixel_items = 0;
    int read_items = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v == 0) return 1;
        return v > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : v;
    endfunction

    function automatic int unsigned stored_back(input int unsigned off);
        return pixel_store[(store_ptr + STORE_DEPTH - (off % STORE_DEPTH)) % STORE_DEPTH];
    endfunction

    function automatic int unsigned abs_diff_avg(input int unsigned a, input int unsigned b,
                                                 input int unsigned mid);
        int unsigned avg;
        avg = (a + b + 1) >> 1;
        return avg > mid ? avg - mid : mid - avg;
    endfunction

    task automatic predict_histogram(input logic mode, input logic [PIX_W-1:0] pix,
                                     input logic [BIN_W-1:0] bin);
        int unsigned w, h, s, ind, y, sw, dx, dy, d;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        s = cfg_step;
        ind = cfg_indent;
        if (mode == MODE_READ) begin
            expected_counts.push_back(hist_count[bin][COUNT_W-1:0]);
            return;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        if (row_pos == 0 && col_pos == 0) foreach (hist_count[i]) hist_count[i] = 0;
        if (s >= 1 && s <= DEF_MAX_STEP && ind >= s && w > 2 * ind && h > 2 * ind
                && row_pos >= s) begin
            y = row_pos - s;
            if (y >= ind && y < h - ind && col_pos >= ind && col_pos < w - ind) begin
                sw = s * w;
                dx = abs_diff_avg(stored_back(sw + s), stored_back(sw - s), stored_back(sw));
                dy = abs_diff_avg(stored_back(2 * sw), pix, stored_back(sw));
                d = dx > dy ? dx : dy;
                if (hist_count[d] < COUNT_MAX) hist_count[d]++;
            end
        end
        pixel_store[store_ptr] = pix;
        store_ptr = (store_ptr + 1) % STORE_DEPTH;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin
        logic any_accept;
        any_accept = aresetn && ((s_valid && s_ready) || (m_valid && m_ready));
        if (aresetn && s_valid && s_ready) begin
            if (s_mode == MODE_READ) read_items++;
            else pixel_items++;
            predict_histogram(s_mode, s_pixel, s_bin_index);
        end
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_counts.size() == 0) begin
                report_mismatch("unexpected bin_count", m_bin_count, 0);
            end else begin
                logic [COUNT_W-1:0] want;
                want = expected_counts.pop_front();
                if (m_bin_count !== want) report_mismatch("bin_count", m_bin_count, want);
                if (fixed_valid.size() != 0) begin
                    if (fixed_valid.pop_front() && m_bin_count !== fixed_counts[0])
                        report_mismatch("table bin_count", m_bin_count, fixed_counts[0]);
                    void'(fixed_counts.pop_front());
                end
            end
        end
        if (any_accept) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", expected_counts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (recv_idle_pct == 0) m_ready <= 1'b1;
        else m_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix,
                             input logic [BIN_W-1:0] bin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_pixel <= pix;
        s_bin_index <= bin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH: cfg_width = value & 12'hFFF;
            REG_HEIGHT: cfg_height = value & 12'hFFF;
            REG_STEP: cfg_step = value & 5'h1F;
            default: cfg_indent = value & 5'h1F;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned s, input int unsigned ind);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_STEP, s);
        write_reg(REG_INDENT, ind);
    endtask

    // whole frame in the current geometry, optionally flat or extreme content
    task automatic send_frame(input int kind);
        int unsigned n;
        logic [PIX_W-1:0] p;
        n = clamp_dim(cfg_width) * clamp_dim(cfg_height);
        for (int unsigned i = 0; i < n; i++) begin
            case (kind)
                0: p = $urandom_range(255);
                1: p = (i % 2) ? 8'hFF : 8'h00;
                default: p = 8'h80;
            endcase
            send_item(MODE_PIXEL, p, $urandom_range(255));
            if ($urandom_range(29) == 0) send_item(MODE_READ, $urandom_range(255), $urandom_range(255));
        end
    endtask

    task automatic read_bins(input int unsigned num);
        for (int unsigned i = 0; i < num; i++)
            send_item(MODE_READ, $urandom_range(255), $urandom_range(255));
    endtask

    stim_row_t directed_rows [16] = '{
        '{MODE_READ, 8'h00, 8'h00, 1'b1, 23'd0},
        '{MODE_READ, 8'hFF, 8'hFF, 1'b1, 23'd0},
        '{MODE_READ, 8'h5A, 8'hA5, 1'b1, 23'd0},
        '{MODE_PIXEL, 8'h00, 8'hFF, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'hFF, 8'h00, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'h00, 8'hFF, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'hFF, 8'h00, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'h00, 8'hFF, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'hFF, 8'h00, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'h00, 8'hFF, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'hFF, 8'h00, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'h00, 8'hFF, 1'b0, 23'd0},
        '{MODE_READ, 8'h00, 8'd255, 1'b0, 23'd0},
        '{MODE_READ, 8'h00, 8'd0, 1'b0, 23'd0},
        '{MODE_PIXEL, 8'h12, 8'h00, 1'b0, 23'd0},
        '{MODE_READ, 8'h00, 8'd0, 1'b1, 23'd0}
    };

    initial begin
        int kind;
        foreach (hist_count[i]) hist_count[i] = 0;
        foreach (pixel_store[i]) pixel_store[i] = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 3x3 frame: checkerboard gives center 0x00 against 0xFF neighbors
        set_geometry(3, 3, 1, 1);
        foreach (directed_rows[i]) begin
            fixed_valid.push_back(directed_rows[i].check_fixed);
            if (directed_rows[i].mode == MODE_PIXEL) void'(fixed_valid.pop_back());
            else fixed_counts.push_back(directed_rows[i].fixed_count);
            send_item(directed_rows[i].mode, directed_rows[i].pixel,
                      directed_rows[i].bin_index);
        end
        wait_drained();
        fixed_valid.delete();
        fixed_counts.delete();

        // bad configurations and a clamped width count nothing; step 16 on 33x33 counts one center
        set_geometry(4, 4, 2, 1);
        send_frame(0);
        read_bins(4);
        set_geometry(0, 0, 0, 0);
        send_frame(0);
        read_bins(2);
        set_geometry(4095, 3, 17, 31);
        read_bins(2);
        set_geometry(33, 33, 16, 16);
        send_frame(0);
        read_bins(6);

        for (int phase = 0; phase < 3; phase++) begin
            int unsigned s, ind;
            send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 49 : 0);
            recv_idle_pct = phase == 0 ? 49 : (phase == 1 ? 23 : 0);
            s = $urandom_range(3, 1);
            ind = $urandom_range(4, s);
            set_geometry($urandom_range(2 * ind + 4, 2 * ind + 1),
                         $urandom_range(2 * ind + 5, 2 * ind + 1), s, ind);
            kind = $urandom_range(9) == 0 ? 1 : ($urandom_range(9) == 0 ? 2 : 0);
            send_frame(kind);
            read_bins(8);
            if ($urandom_range(3) == 0) begin
                send_item(MODE_PIXEL, $urandom_range(255), $urandom_range(255));
                read_bins(2);
            end
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        repeat (20) @(negedge aclk);
        $display("covered %0d pixel items and %0d bin reads, %0d results checked",
                 pixel_items, read_items, result_count);
        $display("geometries from 1x1 to clamped 2048 wide, steps 1 to 16, three idling phases");
        if (error_count == 0 && expected_counts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
